>>> sv/stereo_input_strip_with_peak_meter_macros.svh
// assertion macros shared by the strip's checker
`ifndef STEREO_INPUT_STRIP_WITH_PEAK_METER_MACROS_SVH
`define STEREO_INPUT_STRIP_WITH_PEAK_METER_MACROS_SVH

// property checked outside reset
`define SISP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define SISP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/sisp_pkg.sv
// types and constants of the stereo input strip
`timescale 1ns / 1ps

package sisp_pkg;

   localparam int GAIN_W     = 16;
   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_NORMAL = 2'd0,
      MODE_SWAP   = 2'd1,
      MODE_LEFT   = 2'd2,
      MODE_RIGHT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_INPUT_MODE    = 2'd0,
      REG_CHANNEL_COUNT = 2'd1,
      REG_GAIN          = 2'd2,
      REG_RECORD_ENABLE = 2'd3
   } reg_index_type;

   localparam logic [COUNT_W-1:0] COUNT_MONO   = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_STEREO = 2'd2;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd4096;

   typedef struct packed {
      mode_type             input_mode;
      logic [COUNT_W-1:0]   channel_count;
      logic [GAIN_W-1:0]    gain;
      logic                 record_enable;
   } cfg_type;

endpackage

>>> sv/stereo_input_strip_with_peak_meter.sv
// top level of the stereo input strip with block peak meter
//
//   channel   direction   ports                                  transfer when
//   req       in          left/right sample, last_in_block       req_valid & req_ready
//   rsp       out         rec valid/left/right, meter v/l/r      rsp_valid & rsp_ready
//   csr       in/out      apb-style, regs at 4*i                 psel & penable & pwrite
//
// one frame per cycle sustained while rsp_ready stays high; after the req transfer a frame passes
// the input register, then gain multiply, round and saturate into the result register
// reset is synchronous, active high; it restores register defaults and clears both peaks
// a stalled rsp holds the result; the input register still takes one more frame,
// then req_ready drops until the result is taken
`timescale 1ns / 1ps

module stereo_input_strip_with_peak_meter import sisp_pkg::*; #(
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // input frames
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_left_sample,
   input  logic [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                   req_last_in_block,
   // results
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_rec_valid,
   output logic [SAMPLE_BITS-1:0] rsp_rec_left,
   output logic [SAMPLE_BITS-1:0] rsp_rec_right,
   output logic                   rsp_meter_valid,
   output logic [SAMPLE_BITS-2:0] rsp_meter_left,
   output logic [SAMPLE_BITS-2:0] rsp_meter_right,
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type cfg;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic                   last_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rec_valid_ff;
   logic [SAMPLE_BITS-1:0] rec_left_ff, rec_right_ff;
   logic                   meter_valid_ff;
   logic [SAMPLE_BITS-2:0] meter_left_ff, meter_right_ff;

   // handshake control
   logic advance;
   logic in_take;
   logic fire;

   // datapath
   logic signed [SAMPLE_BITS:0]   left_ext, right_ext, sum_lr;
   logic signed [SAMPLE_BITS:0]   lane_a_x, lane_b_x;
   logic        [SAMPLE_BITS-1:0] lane_a_y, lane_b_y;
   logic                          rec_on, is_mono, use_a, use_b;
   logic                          meter_valid;
   logic        [SAMPLE_BITS-2:0] meter_left, meter_right;

   sisp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // the result register moves when empty or taken; the input register refills behind it
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign in_take   = req_valid && req_ready;
   assign fire      = in_valid_ff && advance;

   assign in_valid_in  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         left_ff  <= req_left_sample;
         right_ff <= req_right_sample;
         last_ff  <= req_last_in_block;
      end
   end

   // one bit of headroom so the mono sum never wraps before the gain
   assign left_ext  = $signed({left_ff[SAMPLE_BITS-1], left_ff});
   assign right_ext = $signed({right_ff[SAMPLE_BITS-1], right_ff});
   assign sum_lr    = left_ext + right_ext;

   // any channel count other than mono or stereo records nothing
   assign is_mono = (cfg.channel_count == COUNT_MONO);
   assign rec_on  = cfg.record_enable
                    && (cfg.channel_count == COUNT_MONO || cfg.channel_count == COUNT_STEREO);

   // lane a feeds rec_left (or mono), lane b feeds rec_right
   always_comb begin
      lane_a_x = left_ext;
      lane_b_x = right_ext;
      use_a    = 1'b1;
      use_b    = 1'b1;
      if (is_mono) begin
         use_b = 1'b0;
         case (cfg.input_mode)
            MODE_LEFT:  lane_a_x = left_ext;
            MODE_RIGHT: lane_a_x = right_ext;
            default:    lane_a_x = sum_lr;
         endcase
      end else begin
         case (cfg.input_mode)
            MODE_SWAP: begin
               lane_a_x = right_ext;
               lane_b_x = left_ext;
            end
            MODE_LEFT:  use_b = 1'b0;
            MODE_RIGHT: use_a = 1'b0;
            default: begin
            end
         endcase
      end
   end

   sisp_gain #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_gain_a (
      .x    (lane_a_x),
      .gain (cfg.gain),
      .y    (lane_a_y)
   );

   sisp_gain #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_gain_b (
      .x    (lane_b_x),
      .gain (cfg.gain),
      .y    (lane_b_y)
   );

   // peaks see the raw samples, routed by mode, whether recording or not
   sisp_peak #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_peak (
      .clock       (clock),
      .reset       (reset),
      .update      (fire),
      .input_mode  (cfg.input_mode),
      .left        (left_ff),
      .right       (right_ff),
      .last        (last_ff),
      .meter_valid (meter_valid),
      .meter_left  (meter_left),
      .meter_right (meter_right)
   );

   always_ff @(posedge clock) begin
      if (fire) begin
         rec_valid_ff   <= rec_on;
         rec_left_ff    <= (rec_on && use_a) ? lane_a_y : '0;
         rec_right_ff   <= (rec_on && use_b) ? lane_b_y : '0;
         meter_valid_ff <= meter_valid;
         meter_left_ff  <= meter_left;
         meter_right_ff <= meter_right;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rec_valid   = rec_valid_ff;
   assign rsp_rec_left    = rec_left_ff;
   assign rsp_rec_right   = rec_right_ff;
   assign rsp_meter_valid = meter_valid_ff;
   assign rsp_meter_left  = meter_left_ff;
   assign rsp_meter_right = meter_right_ff;

endmodule

>>> sv/sisp_csr.sv
// control and status registers of the stereo input strip
`timescale 1ns / 1ps

module sisp_csr import sisp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_INPUT_MODE:    cfg_in.input_mode    = mode_type'(csr_pwdata[MODE_W-1:0]);
            REG_CHANNEL_COUNT: cfg_in.channel_count = csr_pwdata[COUNT_W-1:0];
            REG_GAIN:          cfg_in.gain          = csr_pwdata[GAIN_W-1:0];
            REG_RECORD_ENABLE: cfg_in.record_enable = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_mode    <= MODE_NORMAL;
         cfg_ff.channel_count <= COUNT_STEREO;
         cfg_ff.gain          <= GAIN_RESET;
         cfg_ff.record_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_INPUT_MODE:    csr_prdata = CSR_DATA_W'(cfg_ff.input_mode);
         REG_CHANNEL_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.channel_count);
         REG_GAIN:          csr_prdata = CSR_DATA_W'(cfg_ff.gain);
         REG_RECORD_ENABLE: csr_prdata = CSR_DATA_W'(cfg_ff.record_enable);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

>>> sv/sisp_gain.sv
// one gain lane: multiply, round half up, saturate
`timescale 1ns / 1ps

module sisp_gain import sisp_pkg::*; #(
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic signed [SAMPLE_BITS:0]   x,
   input  logic        [GAIN_W-1:0]      gain,
   output logic        [SAMPLE_BITS-1:0] y
);

   localparam int PW   = SAMPLE_BITS + 1 + GAIN_W + 1;
   localparam int HI_W = PW - SAMPLE_BITS + 1;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (GAIN_FRAC_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [GAIN_W:0] gain_s;
   logic signed [PW-1:0]   prod;
   logic signed [PW-1:0]   scaled;
   logic        [HI_W-1:0] hi;

   assign gain_s = $signed({1'b0, gain});
   assign prod   = x * gain_s;
   // arithmetic shift is a floor, so adding half first rounds ties upward
   assign scaled = (prod + HALF) >>> GAIN_FRAC_BITS;
   assign hi     = scaled[PW-1:SAMPLE_BITS-1];

   always_comb begin
      if (hi == '0 || hi == '1) begin
         y = scaled[SAMPLE_BITS-1:0];
      end else if (scaled[PW-1]) begin
         y = SAT_MIN;
      end else begin
         y = SAT_MAX;
      end
   end

endmodule

>>> sv/sisp_peak.sv
// block peak meter with floor zero, cleared after the last frame
`timescale 1ns / 1ps

module sisp_peak import sisp_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   update,
   input  mode_type               input_mode,
   input  logic [SAMPLE_BITS-1:0] left,
   input  logic [SAMPLE_BITS-1:0] right,
   input  logic                   last,
   output logic                   meter_valid,
   output logic [SAMPLE_BITS-2:0] meter_left,
   output logic [SAMPLE_BITS-2:0] meter_right
);

   logic [SAMPLE_BITS-2:0] peak_left_ff, peak_left_in;
   logic [SAMPLE_BITS-2:0] peak_right_ff, peak_right_in;
   logic [SAMPLE_BITS-1:0] cand_left, cand_right;
   logic                   use_left, use_right;
   logic [SAMPLE_BITS-2:0] new_left, new_right;

   always_comb begin
      cand_left  = left;
      cand_right = right;
      use_left   = 1'b1;
      use_right  = 1'b1;
      case (input_mode)
         MODE_NORMAL: begin
         end
         MODE_SWAP: begin
            cand_left  = right;
            cand_right = left;
         end
         MODE_LEFT:  use_right = 1'b0;
         MODE_RIGHT: use_left  = 1'b0;
         default: begin
         end
      endcase
   end

   // negative samples never raise a peak
   assign new_left  = (use_left && !cand_left[SAMPLE_BITS-1]
                       && cand_left[SAMPLE_BITS-2:0] > peak_left_ff)
                      ? cand_left[SAMPLE_BITS-2:0] : peak_left_ff;
   assign new_right = (use_right && !cand_right[SAMPLE_BITS-1]
                       && cand_right[SAMPLE_BITS-2:0] > peak_right_ff)
                      ? cand_right[SAMPLE_BITS-2:0] : peak_right_ff;

   assign meter_valid = last;
   assign meter_left  = last ? new_left  : '0;
   assign meter_right = last ? new_right : '0;

   always_comb begin
      peak_left_in  = peak_left_ff;
      peak_right_in = peak_right_ff;
      if (update) begin
         peak_left_in  = last ? '0 : new_left;
         peak_right_in = last ? '0 : new_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_left_ff  <= '0;
         peak_right_ff <= '0;
      end else begin
         peak_left_ff  <= peak_left_in;
         peak_right_ff <= peak_right_in;
      end
   end

endmodule

>>> sv/sisp_checker.sv
// port-level checks of the stereo input strip and their bind
`timescale 1ns / 1ps
`include "stereo_input_strip_with_peak_meter_macros.svh"

module sisp_checker import sisp_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [SAMPLE_BITS-1:0] req_left_sample,
   input logic [SAMPLE_BITS-1:0] req_right_sample,
   input logic                   req_last_in_block,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_rec_valid,
   input logic [SAMPLE_BITS-1:0] rsp_rec_left,
   input logic [SAMPLE_BITS-1:0] rsp_rec_right,
   input logic                   rsp_meter_valid,
   input logic [SAMPLE_BITS-2:0] rsp_meter_left,
   input logic [SAMPLE_BITS-2:0] rsp_meter_right,
   input logic                   csr_psel,
   input logic                   csr_penable,
   input logic                   csr_pwrite,
   input logic [CSR_ADDR_W-1:0]  csr_paddr,
   input logic [CSR_DATA_W-1:0]  csr_pwdata,
   input logic [CSR_DATA_W-1:0]  csr_prdata,
   input logic                   csr_pready
);

   // a stalled result stays offered
   `SISP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // no recording means zero samples
   `SISP_ASSERT(a_rec_zero, clock, reset, rsp_valid && !rsp_rec_valid |-> rsp_rec_left == '0 && rsp_rec_right == '0, "samples set while not recording")

   // meter fields are zero except on the last frame of a block
   `SISP_ASSERT(a_meter_zero, clock, reset, rsp_valid && !rsp_meter_valid |-> rsp_meter_left == '0 && rsp_meter_right == '0, "meter set off block end")

   // a taken result always frees room for a new frame
   `SISP_ASSERT_ALWAYS(a_ready_follows, clock, rsp_ready |-> req_ready, "input blocked while output drains")

   // nothing is offered right after reset
   `SISP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result offered after reset")

endmodule

bind stereo_input_strip_with_peak_meter sisp_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_sisp_checker (.*);

>>> bench/stereo_input_strip_with_peak_meter_tb.sv
// self-checking testbench for the stereo input strip with block peak meter
`timescale 1ns / 1ps

module stereo_input_strip_with_peak_meter_tb;
   import sisp_pkg::*;

   localparam int SAMPLE_W     = 24;
   localparam int FRAC_W       = 12;
   localparam int CYCLE_LIMIT  = 400000;
   // margin after the last result so the pipeline is empty
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_PRINTED  = 100;
   localparam int EPOCH_FRAMES = 84;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_ONE = '1;

   // channel counts that record nothing
   localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
   localparam logic [COUNT_W-1:0] COUNT_OVER = 2'd3;

   // one result transfer as the block should produce it
   typedef struct packed {
      logic                rec_valid;
      logic [SAMPLE_W-1:0] rec_left;
      logic [SAMPLE_W-1:0] rec_right;
      logic                meter_valid;
      logic [SAMPLE_W-2:0] meter_left;
      logic [SAMPLE_W-2:0] meter_right;
   } strip_result_type;

   // clock and synchronous reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // every input starts at a known value
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_left_sample   = '0;
   logic [SAMPLE_W-1:0]    req_right_sample  = '0;
   logic                   req_last_in_block = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic                   rsp_rec_valid;
   logic [SAMPLE_W-1:0]    rsp_rec_left;
   logic [SAMPLE_W-1:0]    rsp_rec_right;
   logic                   rsp_meter_valid;
   logic [SAMPLE_W-2:0]    rsp_meter_left;
   logic [SAMPLE_W-2:0]    rsp_meter_right;
   logic                   csr_psel          = 1'b0;
   logic                   csr_penable       = 1'b0;
   logic                   csr_pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr         = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata        = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // bench-side copy of the registers and the two peak meters
   cfg_type             strip_cfg;
   logic [SAMPLE_W-2:0] left_peak;
   logic [SAMPLE_W-2:0] right_peak;

   // results predicted at req transfer, oldest first
   strip_result_type pending_results[$];

   int mismatch_count  = 0;
   int sender_idle_pct = 0;
   int recv_idle_pct   = 0;
   int unsigned cycle_count = 0;

   always #10 clock = ~clock;

   stereo_input_strip_with_peak_meter #(
      .SAMPLE_BITS    (SAMPLE_W),
      .GAIN_FRAC_BITS (FRAC_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .req_last_in_block (req_last_in_block),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rec_valid     (rsp_rec_valid),
      .rsp_rec_left      (rsp_rec_left),
      .rsp_rec_right     (rsp_rec_right),
      .rsp_meter_valid   (rsp_meter_valid),
      .rsp_meter_left    (rsp_meter_left),
      .rsp_meter_right   (rsp_meter_right),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // ---------------------------------------------------------------- predictor

   // exact product, round half up, saturate to the sample range
   function automatic logic [SAMPLE_W-1:0] gained(longint x);
      longint prod;
      longint q;
      prod = x * longint'(strip_cfg.gain);
      q = (prod + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
      if (q > longint'(signed'(SAMPLE_MAX))) q = longint'(signed'(SAMPLE_MAX));
      if (q < longint'(signed'(SAMPLE_MIN))) q = longint'(signed'(SAMPLE_MIN));
      return q[SAMPLE_W-1:0];
   endfunction

   // peak with floor zero, negatives never raise it
   function automatic logic [SAMPLE_W-2:0] raised(logic [SAMPLE_W-2:0] peak, longint s);
      if (s > 0 && s > longint'(peak)) return s[SAMPLE_W-2:0];
      return peak;
   endfunction

   // one frame through the strip: recorded pair plus meter, updates the peaks
   function automatic strip_result_type strip_predict(logic [SAMPLE_W-1:0] l_bits,
                                                      logic [SAMPLE_W-1:0] r_bits,
                                                      logic last);
      strip_result_type res;
      longint l;
      longint r;
      l = longint'(signed'(l_bits));
      r = longint'(signed'(r_bits));
      res = '0;
      if (strip_cfg.record_enable &&
          (strip_cfg.channel_count == COUNT_MONO ||
           strip_cfg.channel_count == COUNT_STEREO)) begin
         res.rec_valid = 1'b1;
         if (strip_cfg.channel_count == COUNT_MONO) begin
            // mono sum is formed one bit wider and saturated after the gain
            case (strip_cfg.input_mode)
               MODE_RIGHT: res.rec_left = gained(r);
               MODE_LEFT:  res.rec_left = gained(l);
               default:    res.rec_left = gained(l + r);
            endcase
         end else begin
            case (strip_cfg.input_mode)
               MODE_RIGHT: res.rec_right = gained(r);
               MODE_LEFT:  res.rec_left  = gained(l);
               MODE_SWAP: begin
                  res.rec_left  = gained(r);
                  res.rec_right = gained(l);
               end
               default: begin
                  res.rec_left  = gained(l);
                  res.rec_right = gained(r);
               end
            endcase
         end
      end
      // meters see the raw samples, routed by mode
      case (strip_cfg.input_mode)
         MODE_RIGHT: right_peak = raised(right_peak, r);
         MODE_LEFT:  left_peak  = raised(left_peak, l);
         MODE_SWAP: begin
            right_peak = raised(right_peak, l);
            left_peak  = raised(left_peak, r);
         end
         default: begin
            left_peak  = raised(left_peak, l);
            right_peak = raised(right_peak, r);
         end
      endcase
      if (last) begin
         res.meter_valid = 1'b1;
         res.meter_left  = left_peak;
         res.meter_right = right_peak;
         left_peak  = '0;
         right_peak = '0;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch on %s: got %h, expected %h", what, got, want);
   endtask

   // rsp_ready is redrawn every edge; a transfer is checked against the oldest prediction
   always @(posedge clock) begin
      strip_result_type want;
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("unexpected rsp transfer", 32'd1, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_rec_valid !== want.rec_valid)
               flag_mismatch("rec_valid", rsp_rec_valid, want.rec_valid);
            if (rsp_rec_left !== want.rec_left)
               flag_mismatch("rec_left", rsp_rec_left, want.rec_left);
            if (rsp_rec_right !== want.rec_right)
               flag_mismatch("rec_right", rsp_rec_right, want.rec_right);
            if (rsp_meter_valid !== want.meter_valid)
               flag_mismatch("meter_valid", rsp_meter_valid, want.meter_valid);
            if (rsp_meter_left !== want.meter_left)
               flag_mismatch("meter_left", rsp_meter_left, want.meter_left);
            if (rsp_meter_right !== want.meter_right)
               flag_mismatch("meter_right", rsp_meter_right, want.meter_right);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // one frame transfer; valid stays high afterwards until the next call or a settle
   task automatic send_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_left_sample   <= l;
      req_right_sample  <= r;
      req_last_in_block <= last;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(strip_predict(l, r, last));
   endtask

   // stop sending, wait for every result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // apb write while idle; bits above the field width are sometimes set
   task automatic csr_write(reg_index_type idx, logic [31:0] field);
      logic [31:0] data;
      int w;
      case (idx)
         REG_INPUT_MODE:    w = MODE_W;
         REG_CHANNEL_COUNT: w = COUNT_W;
         REG_GAIN:          w = GAIN_W;
         default:           w = 1;
      endcase
      data = field & ((32'd1 << w) - 32'd1);
      if ($urandom_range(0, 1) == 1) data = data | ($urandom() << w);
      settle();
      // setup phase
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      // access phase, register written at the edge where pready is seen
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_INPUT_MODE:    strip_cfg.input_mode    = mode_type'(data[MODE_W-1:0]);
         REG_CHANNEL_COUNT: strip_cfg.channel_count = data[COUNT_W-1:0];
         REG_GAIN:          strip_cfg.gain          = data[GAIN_W-1:0];
         default:           strip_cfg.record_enable = data[0];
      endcase
      @(posedge clock);
   endtask

   // samples weighted toward the extremes and the area around zero
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return SAMPLE_NEG_ONE;
         4:       return SAMPLE_W'($urandom_range(0, 32)) - SAMPLE_W'(16);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // reset values: recording off, stereo normal, unity gain, meters still run
   task automatic test_defaults();
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame(SAMPLE_NEG_ONE, SAMPLE_W'(1), 1'b1);
      settle();
   endtask

   // every mode in mono and stereo, then the counts that record nothing
   task automatic test_routing();
      logic [COUNT_W-1:0] counts[2];
      counts[0] = COUNT_MONO;
      counts[1] = COUNT_STEREO;
      csr_write(REG_RECORD_ENABLE, 32'd1);
      foreach (counts[c]) begin
         csr_write(REG_CHANNEL_COUNT, 32'(counts[c]));
         for (int m = 0; m < 4; m++) begin
            csr_write(REG_INPUT_MODE, 32'(m));
            send_frame(SAMPLE_W'(5000000), SAMPLE_W'(2500000), 1'b1);
         end
      end
      // negative sample on the normal route must not lift a peak
      csr_write(REG_INPUT_MODE, 32'(MODE_NORMAL));
      csr_write(REG_CHANNEL_COUNT, 32'(COUNT_NONE));
      send_frame(SAMPLE_W'(1234567), SAMPLE_NEG_ONE, 1'b1);
      csr_write(REG_CHANNEL_COUNT, 32'(COUNT_OVER));
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
   endtask

   // mute, full gain saturation, round-half-up ties, mono sum saturation
   task automatic test_gain_rounding();
      csr_write(REG_CHANNEL_COUNT, 32'(COUNT_STEREO));
      csr_write(REG_INPUT_MODE, 32'(MODE_NORMAL));
      csr_write(REG_GAIN, 32'd0);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      csr_write(REG_GAIN, 32'd65535);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_frame(SAMPLE_W'(1), SAMPLE_NEG_ONE, 1'b0);
      // half gain puts odd samples exactly on a tie
      csr_write(REG_GAIN, 32'd2048);
      send_frame(SAMPLE_W'(1), SAMPLE_NEG_ONE, 1'b0);
      send_frame(SAMPLE_W'(3), -SAMPLE_W'(3), 1'b1);
      csr_write(REG_GAIN, 32'(GAIN_RESET));
      csr_write(REG_CHANNEL_COUNT, 32'(COUNT_MONO));
      send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
      send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
   endtask

   // random settings and block-shaped traffic under three idling patterns
   task automatic test_random_traffic();
      int sender_pct[3];
      int recv_pct[3];
      int sent;
      int blk;
      logic last;
      logic [COUNT_W-1:0] count_pick;
      logic [GAIN_W-1:0] gain_pick;
      sender_pct = '{26, 63, 0};
      recv_pct   = '{63, 26, 0};
      for (int phase = 0; phase < 3; phase++) begin
         for (int epoch = 0; epoch < 7; epoch++) begin
            csr_write(REG_INPUT_MODE, 32'($urandom_range(0, 3)));
            case ($urandom_range(0, 9))
               0, 1, 2, 3:    count_pick = COUNT_MONO;
               8:             count_pick = COUNT_NONE;
               9:             count_pick = COUNT_OVER;
               default:       count_pick = COUNT_STEREO;
            endcase
            csr_write(REG_CHANNEL_COUNT, 32'(count_pick));
            case ($urandom_range(0, 5))
               0:       gain_pick = '0;
               1:       gain_pick = '1;
               2:       gain_pick = GAIN_RESET;
               3:       gain_pick = GAIN_W'(2048);
               default: gain_pick = GAIN_W'($urandom());
            endcase
            csr_write(REG_GAIN, 32'(gain_pick));
            csr_write(REG_RECORD_ENABLE, 32'($urandom_range(0, 4) != 0));
            // sender idling applies only to the frames of this epoch; receiver idling stays until the test ends
            sender_idle_pct = sender_pct[phase];
            recv_idle_pct   = recv_pct[phase];
            sent = 0;
            while (sent < EPOCH_FRAMES) begin
               blk = $urandom_range(1, 12);
               if ($urandom_range(0, 9) == 0) blk = $urandom_range(13, 60);
               for (int i = 0; i < blk && sent < EPOCH_FRAMES; i++) begin
                  last = (i == blk - 1);
                  // occasional stray or missing block end
                  if ($urandom_range(0, 19) == 0) last = 1'($urandom_range(0, 1));
                  send_frame(pick_sample(), pick_sample(), last);
                  sent++;
               end
            end
            sender_idle_pct = 0;
         end
      end
      recv_idle_pct = 0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      strip_cfg.input_mode    = MODE_NORMAL;
      strip_cfg.channel_count = COUNT_STEREO;
      strip_cfg.gain          = GAIN_RESET;
      strip_cfg.record_enable = 1'b0;
      left_peak  = '0;
      right_peak = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_routing();
      test_gain_rounding();
      test_random_traffic();
      settle();
      if (mismatch_count == 0)
         $display("stereo_input_strip_with_peak_meter verification clean");
      else
         $display("stereo_input_strip_with_peak_meter verification failed");
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("stereo_input_strip_with_peak_meter verification failed");
      $finish;
   end

endmodule

>>> stereo_input_strip_with_peak_meter.f
+incdir+sv
sv/sisp_pkg.sv
sv/sisp_csr.sv
sv/sisp_gain.sv
sv/sisp_peak.sv
sv/stereo_input_strip_with_peak_meter.sv
sv/sisp_checker.sv
bench/stereo_input_strip_with_peak_meter_tb.sv
